[hdl/interval_range_map_assert.svh]
// assertion macros shared by the checker
`ifndef INTERVAL_RANGE_MAP_ASSERT_SVH
`define INTERVAL_RANGE_MAP_ASSERT_SVH

// same-cycle implication under reset
`define IRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("interval_range_map check failed");

// next-cycle implication under reset
`define IRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("interval_range_map check failed");

`endif

[hdl/irm_pkg.sv]
`default_nettype none

package irm_pkg;

  localparam int unsigned KeyWidth = 32;
  localparam int unsigned ValWidth = 8;

  typedef logic [KeyWidth-1:0] irm_key_t;
  typedef logic [ValWidth-1:0] irm_val_t;

  localparam logic [1:0] StatDone  = 2'd0;
  localparam logic [1:0] StatEmpty = 2'd1;
  localparam logic [1:0] StatFull  = 2'd2;

  localparam logic ReqAssign = 1'b0;
  localparam logic ReqLookup = 1'b1;

  typedef struct packed {
    logic     req_type;
    irm_key_t start_key;
    irm_key_t end_key;
    irm_val_t fill_value;
  } irm_req_t;

  typedef struct packed {
    irm_val_t   read_value;
    logic [1:0] status;
  } irm_rsp_t;

  typedef struct packed {
    logic tbl_shift;
    logic scr_shift;
    logic commit;
  } irm_cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/irm_cell.sv]
`default_nettype none

module irm_cell import irm_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  irm_cell_ctrl_t ctrl_i,
  input  wire            act_i,
  input  irm_key_t       cmp_key_i,
  input  irm_key_t       tbl_nxt_key_i,
  input  irm_val_t       tbl_nxt_val_i,
  input  irm_key_t       scr_nxt_key_i,
  input  irm_val_t       scr_nxt_val_i,
  input  wire            le_nxt_i,
  output irm_key_t       tbl_key_o,
  output irm_val_t       tbl_val_o,
  output irm_key_t       scr_key_o,
  output irm_val_t       scr_val_o,
  output logic           le_o,
  output irm_val_t       sel_val_o
);

  irm_key_t tbl_key_q, scr_key_q;
  irm_val_t tbl_val_q, scr_val_q;
  logic     le_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      tbl_key_q <= scr_key_q;
      tbl_val_q <= scr_val_q;
    end else if (ctrl_i.tbl_shift) begin
      tbl_key_q <= tbl_nxt_key_i;
      tbl_val_q <= tbl_nxt_val_i;
    end
    if (ctrl_i.scr_shift) begin
      scr_key_q <= scr_nxt_key_i;
      scr_val_q <= scr_nxt_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b0;
    end else begin
      le_q <= act_i && (tbl_key_q <= cmp_key_i);
    end
  end

  assign tbl_key_o = tbl_key_q;
  assign tbl_val_o = tbl_val_q;
  assign scr_key_o = scr_key_q;
  assign scr_val_o = scr_val_q;
  assign le_o      = le_q;
  assign sel_val_o = (le_q && !le_nxt_i) ? tbl_val_q : '0;

endmodule

`default_nettype wire

[hdl/interval_range_map.sv]
// Interval map over 32-bit keys with up to TABLE_DEPTH boundaries held in a row of cells.
// A lookup first has every cell compare its key in parallel, then the last match is
// selected. An empty-range assign is answered straight from the idle state. Any other
// assign rotates the table once through the cell row while the rebuilt table shifts into
// the scratch row, which then rotates into place and is committed; an assign whose
// rebuilt table holds more than TABLE_DEPTH boundaries is rejected as full before that
// alignment. One request is in work at a time; a finished result may wait in the output
// register while the next request is accepted. The table needs no clearing after reset.
`default_nettype none

module interval_range_map import irm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_stall_o,
  input  irm_req_t in_data_i,
  output logic     out_valid_o,
  input  wire      out_stall_i,
  output irm_rsp_t out_data_o,
  input  wire      cfg_valid_i,
  output logic     cfg_ready_o,
  input  irm_val_t cfg_data_i
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 2);
  localparam logic [CntW-1:0] Depth = CntW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    StIdle, StLook, StAend, StRead, StInsE, StAlign, StResp
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   j_q, j_d, m_q, m_d, entry_cnt_q, entry_cnt_d;
  logic              ins_q, ins_d, out_valid_q, out_valid_d;
  irm_val_t          last_q, last_d, ev_q, ev_d, dflt_q;
  irm_req_t          req_q, req_d;
  irm_rsp_t          res_q, res_d, out_data_q, out_data_d;

  irm_cell_ctrl_t    ctrl;
  irm_key_t          cmp_key, push_key, scr_feed_key;
  irm_val_t          push_val, scr_feed_val, look_val, sel_or;
  logic              push, fin;
  irm_rsp_t          fin_rsp;

  irm_key_t tbl_key [TABLE_DEPTH];
  irm_val_t tbl_val [TABLE_DEPTH];
  irm_key_t scr_key [TABLE_DEPTH];
  irm_val_t scr_val [TABLE_DEPTH];
  irm_val_t sel_val [TABLE_DEPTH];
  logic     le      [TABLE_DEPTH+1];

  assign le[TABLE_DEPTH] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int unsigned Nx = (i + 1) % TABLE_DEPTH;
    irm_key_t snk;
    irm_val_t snv;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign snk = scr_feed_key;
      assign snv = scr_feed_val;
    end else begin : g_mid
      assign snk = scr_key[i+1];
      assign snv = scr_val[i+1];
    end
    irm_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .act_i         (CntW'(i) < entry_cnt_q),
      .cmp_key_i     (cmp_key),
      .tbl_nxt_key_i (tbl_key[Nx]),
      .tbl_nxt_val_i (tbl_val[Nx]),
      .scr_nxt_key_i (snk),
      .scr_nxt_val_i (snv),
      .le_nxt_i      (le[i+1]),
      .tbl_key_o     (tbl_key[i]),
      .tbl_val_o     (tbl_val[i]),
      .scr_key_o     (scr_key[i]),
      .scr_val_o     (scr_val[i]),
      .le_o          (le[i]),
      .sel_val_o     (sel_val[i])
    );
  end

  always_comb begin
    sel_or = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_or = sel_or | sel_val[i];
    end
  end

  assign look_val = le[0] ? sel_or : dflt_q;
  assign cmp_key  = (in_data_i.req_type == ReqLookup) ? in_data_i.start_key
                                                      : in_data_i.end_key;
  assign scr_feed_key = (state_q == StAlign) ? scr_key[0] : push_key;
  assign scr_feed_val = (state_q == StAlign) ? scr_val[0] : push_val;

  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    m_d         = m_q;
    entry_cnt_d = entry_cnt_q;
    ins_d       = ins_q;
    last_d      = last_q;
    ev_d        = ev_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ctrl        = '0;
    push        = 1'b0;
    push_key    = req_q.start_key;
    push_val    = req_q.fill_value;
    fin         = 1'b0;
    fin_rsp     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          if (in_data_i.req_type == ReqLookup) begin
            state_d = StLook;
          end else if (in_data_i.start_key >= in_data_i.end_key) begin
            fin            = 1'b1;
            fin_rsp.status = StatEmpty;
          end else begin
            state_d = StAend;
          end
        end
      end
      StLook: begin
        fin                = 1'b1;
        fin_rsp.read_value = look_val;
        fin_rsp.status     = StatDone;
      end
      StAend: begin
        ev_d    = look_val;
        j_d     = '0;
        m_d     = '0;
        ins_d   = 1'b0;
        last_d  = dflt_q;
        state_d = StRead;
      end
      StRead: begin
        if (j_q < entry_cnt_q) begin
          if (!ins_q && tbl_key[0] >= req_q.start_key) begin
            push    = 1'b1;
            state_d = StInsE;
          end else begin
            if (tbl_key[0] < req_q.start_key || tbl_key[0] > req_q.end_key) begin
              push     = 1'b1;
              push_key = tbl_key[0];
              push_val = tbl_val[0];
            end
            ctrl.tbl_shift = 1'b1;
            j_d            = j_q + 1'b1;
          end
        end else if (!ins_q) begin
          push    = 1'b1;
          state_d = StInsE;
        end else if (j_q < Depth) begin
          ctrl.tbl_shift = 1'b1;
          j_d            = j_q + 1'b1;
        end else begin
          j_d     = m_q;
          state_d = StAlign;
        end
      end
      StInsE: begin
        push     = 1'b1;
        push_key = req_q.end_key;
        push_val = ev_q;
        ins_d    = 1'b1;
        state_d  = StRead;
      end
      StAlign: begin
        if (m_q > Depth) begin
          fin            = 1'b1;
          fin_rsp.status = StatFull;
        end else if (j_q < Depth) begin
          ctrl.scr_shift = 1'b1;
          j_d            = j_q + 1'b1;
        end else begin
          ctrl.commit    = 1'b1;
          entry_cnt_d    = m_q;
          fin            = 1'b1;
          fin_rsp.status = StatDone;
        end
      end
      StResp: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (push && push_val != last_q) begin
      ctrl.scr_shift = 1'b1;
      last_d         = push_val;
      m_d            = (m_q > Depth) ? m_q : m_q + 1'b1;
    end

    if (fin) begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_d = 1'b1;
        out_data_d  = fin_rsp;
        state_d     = StIdle;
      end else begin
        res_d   = fin_rsp;
        state_d = StResp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      j_q         <= '0;
      m_q         <= '0;
      entry_cnt_q <= '0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
      dflt_q      <= '0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      m_q         <= m_d;
      entry_cnt_q <= entry_cnt_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        dflt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    ev_q       <= ev_d;
    req_q      <= req_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[hdl/irm_checker.sv]
`default_nettype none

`include "interval_range_map_assert.svh"

module irm_assert_checker import irm_pkg::*; (
  input wire      clk_i,
  input wire      rst_ni,
  input wire      in_valid_i,
  input wire      in_stall_o,
  input irm_req_t in_data_i,
  input wire      out_valid_o,
  input wire      out_stall_i,
  input irm_rsp_t out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  `IRM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `IRM_ASSERT_NEXT(a_one_in_work, in_beat && in_data_i.req_type == ReqLookup, in_stall_o)
  `IRM_ASSERT_NOW(a_status_code, out_valid_o, out_data_o.status != 2'd3)
  `IRM_ASSERT_NOW(a_value_done, out_valid_o && out_data_o.read_value != '0,
                  out_data_o.status == StatDone)

endmodule

bind interval_range_map irm_assert_checker u_irm_checker (.*);

`default_nettype wire

[dv/irm_checker.sv]
`default_nettype none

module irm_checker import irm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  input  wire      in_stall_i,
  input  irm_req_t in_data_i,
  input  wire      out_valid_i,
  input  wire      out_stall_i,
  input  irm_rsp_t out_data_i,
  input  wire      cfg_valid_i,
  input  wire      cfg_ready_i,
  input  irm_val_t cfg_data_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       beats_o,
  output int       full_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  irm_key_t tbl_key[TABLE_DEPTH];
  irm_val_t tbl_val[TABLE_DEPTH];
  int       tbl_count;
  irm_val_t dflt;
  irm_rsp_t rsp_queue[$];

  function automatic irm_val_t map_value(irm_key_t k);
    irm_val_t v;
    v = dflt;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] <= k) v = tbl_val[i];
      else break;
    end
    return v;
  endfunction

  function automatic logic [1:0] apply_assign(irm_key_t s, irm_key_t e, irm_val_t v);
    irm_key_t nk[$];
    irm_val_t nv[$];
    irm_val_t ev;
    irm_val_t prev;
    irm_key_t ck[$];
    irm_val_t cv[$];
    if (!(s < e)) return StatEmpty;
    ev = map_value(e);
    for (int i = 0; i < tbl_count && tbl_key[i] < s; i++) begin
      ck.push_back(tbl_key[i]); cv.push_back(tbl_val[i]);
    end
    ck.push_back(s); cv.push_back(v);
    ck.push_back(e); cv.push_back(ev);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_key[i] > e) begin
        ck.push_back(tbl_key[i]); cv.push_back(tbl_val[i]);
      end
    for (int i = 0; i < ck.size(); i++) begin
      prev = nv.size() ? nv[nv.size()-1] : dflt;
      if (cv[i] != prev && nv.size() < TABLE_DEPTH + 2) begin
        nk.push_back(ck[i]); nv.push_back(cv[i]);
      end
    end
    if (nk.size() > TABLE_DEPTH) return StatFull;
    for (int i = 0; i < nk.size(); i++) begin
      tbl_key[i] = nk[i]; tbl_val[i] = nv[i];
    end
    tbl_count = nk.size();
    return StatDone;
  endfunction

  assign pending_o = rsp_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    irm_rsp_t exp_rsp;
    if (!rst_ni) begin
      tbl_count = 0;
      dflt = '0;
      rsp_queue.delete();
      fail_count_o <= 0;
      beats_o <= 0;
      full_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        beats_o <= beats_o + 1;
        if (rsp_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected beat %h", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_rsp = rsp_queue.pop_front();
          if (exp_rsp.read_value !== out_data_i.read_value ||
              exp_rsp.status !== out_data_i.status) begin
            if (fail_count_o < 10)
              $display("mismatch: exp value %h status %0d, got value %h status %0d",
                       exp_rsp.read_value, exp_rsp.status,
                       out_data_i.read_value, out_data_i.status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.req_type == ReqLookup) begin
          exp_rsp.read_value = map_value(in_data_i.start_key);
          exp_rsp.status = StatDone;
        end else begin
          exp_rsp.read_value = '0;
          exp_rsp.status = apply_assign(in_data_i.start_key, in_data_i.end_key,
                                        in_data_i.fill_value);
          if (exp_rsp.status == StatFull) full_count_o <= full_count_o + 1;
        end
        rsp_queue.push_back(exp_rsp);
      end
      if (cfg_valid_i && cfg_ready_i) dflt = cfg_data_i;
    end
  end

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top import irm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;
  localparam int Limit = 20000;
  localparam int DrainCycles = 4 * Depth + 20;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  irm_req_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  irm_rsp_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  irm_val_t cfg_data = '0;
  int       fail_count, pending, beats, full_count;
  int       idle_cycles = 0;
  bit       quiet = 1'b0;
  bit       hold_off = 1'b0;
  irm_key_t key_pool[8];

  always #5 clk_i = ~clk_i;

  interval_range_map #(.TABLE_DEPTH(Depth)) u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  irm_checker #(.TABLE_DEPTH(Depth)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .beats_o(beats),
    .full_count_o(full_count)
  );

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Limit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(irm_req_t r);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_default(irm_val_t v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic irm_req_t mk(logic t, irm_key_t s, irm_key_t e, irm_val_t v);
    irm_req_t r;
    r.req_type = t; r.start_key = s; r.end_key = e; r.fill_value = v;
    return r;
  endfunction

  function automatic irm_key_t pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return key_pool[$urandom_range(0, 7)];
      2: return key_pool[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  function automatic irm_req_t rand_req();
    irm_key_t a, b;
    a = pick_key();
    b = pick_key();
    if ($urandom_range(0, 2) == 0)
      return mk(ReqLookup, pick_key(), $urandom(), $urandom());
    if ($urandom_range(0, 9) != 0 && a > b) return mk(ReqAssign, b, a, $urandom_range(0, 3));
    return mk(ReqAssign, a, b, $urandom());
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;

    // directed
    send(mk(ReqLookup, '0, '1, 8'hff));
    send(mk(ReqLookup, '1, '0, 8'h00));
    send(mk(ReqAssign, 32'd10, 32'd10, 8'h55));
    send(mk(ReqAssign, 32'd20, 32'd10, 8'h55));
    send(mk(ReqAssign, '0, '1, 8'hff));
    send(mk(ReqLookup, '1, '0, 8'h00));
    send(mk(ReqLookup, 32'hfffffffe, '0, 8'h00));
    send(mk(ReqAssign, '0, '1, 8'h00));
    send(mk(ReqAssign, 32'd100, 32'd200, 8'h00));
    for (int i = 0; i < 10; i++)
      send(mk(ReqAssign, 32'd10 * i * 2 + 1, 32'd10 * i * 2 + 5, 8'(i + 1)));
    send(mk(ReqLookup, 32'd3, '0, '0));
    send(mk(ReqLookup, 32'd0, '0, '0));
    drain();
    write_default(8'hff);
    send(mk(ReqLookup, 32'd0, '0, '0));
    send(mk(ReqAssign, 32'd2, 32'd4, 8'hff));
    send(mk(ReqLookup, 32'd2, '0, '0));
    drain();

    // random phases with default changes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_default(8'h00);
        5: write_default(8'hff);
        default: write_default($urandom_range(0, 3));
      endcase
      if (ph == 2) hold_off = 1'b1;
      if (ph == 5) quiet = 1'b1;
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(0, 40) == 0) send(mk(ReqAssign, '0, '1, $urandom_range(0, 3)));
        else send(rand_req());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
